// ----- rtl/core/json_string_unescape_utf8_macros.svh -----
// Assertion macros shared by the unescaper RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/jsu_pkg.sv -----
// Package for the JSON string unescaper: payload types, character codes,
// queue sizing and the hex / UTF-8 helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Characters of the escape syntax
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_D0     = 8'h30;
    localparam logic [7:0] CH_D9     = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] HEX_TEN   = 8'd10;

    // Control codes produced by the short escapes
    localparam logic [7:0] CODE_BS = 8'h08;
    localparam logic [7:0] CODE_FF = 8'h0C;
    localparam logic [7:0] CODE_LF = 8'h0A;
    localparam logic [7:0] CODE_CR = 8'h0D;
    localparam logic [7:0] CODE_HT = 8'h09;

    localparam int MAX_RUN     = 6;
    localparam int RUN_CNT_W   = $clog2(MAX_RUN + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_byte_valid;
        logic       out_run_last;
        logic       out_string_end;
    } out_item_t;

    // All bytes one input item causes, plus its string end flag
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    count;
        logic                    str_end;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      len;
    } utf8_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c >= CH_D0 && c <= CH_D9) begin
            r.val = 4'(c - CH_D0);
        end else if (c >= CH_LA && c <= CH_LF) begin
            r.val = 4'(c - CH_LA + HEX_TEN);
        end else if (c >= CH_UA && c <= CH_UF) begin
            r.val = 4'(c - CH_UA + HEX_TEN);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Surrogate codes give an empty sequence
    function automatic utf8_t utf8_encode(input logic [15:0] cp);
        utf8_t r;
        r = '0;
        if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
            r.len = 2'd0;
        end else if (cp < 16'h0080) begin
            r.len  = 2'd1;
            r.b[0] = cp[7:0];
        end else if (cp < 16'h0800) begin
            r.len  = 2'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end else begin
            r.len  = 2'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/json_string_unescape_utf8.sv -----
// Top level of the JSON string unescaper with UTF-8 output.
// Instantiates jsu_front, jsu_queue and jsu_back; uses jsu_pkg and the macro header.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   item     | item_valid / item_stall    | in_item_t: escaped byte, end flag
//   result   | result_valid / result_stall| out_item_t: decoded byte, flags
//
// The front takes one byte per cycle while the queue is not full; the back end
// sends one result per cycle unless stalled; a bare end marker gives one result.
// An item's first result passes through its queue entry, then the output register.
// A four-entry run queue sits between them; item_stall rises only when it is full.
// Reset clears the escape phase, the queue and the output valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    run_t    q_data;
    run_t    q_head;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_data     (q_data)
    );

    jsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .q_stat    (q_stat)
    );

    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head         (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `JSU_ASSERT_IMPL(a_no_push_full, q_push, !q_stat.full, "run pushed into full queue")
    `JSU_ASSERT_IMPL(a_no_pop_empty, q_pop, !q_stat.empty, "run popped from empty queue")
    `JSU_ASSERT_IMPL(a_bare_marker, result_valid && !result.out_byte_valid, result.out_run_last && result.out_string_end, "bare marker must close the string")
    `JSU_ASSERT_NEXT(a_pop_shows_last, q_pop, result_valid && result.out_run_last, "retired run left no last result")

endmodule

`default_nettype wire

// ----- rtl/core/jsu_front.sv -----
// Front end of the unescaper: takes one input byte per transaction, runs the
// escape state machine and pushes the decoded bytes as one run. Uses jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  in_item_t item,
    input  q_stat_t  q_stat,
    output logic     q_push,
    output run_t     q_data
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_U    = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_HEX3 = 3'd5
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [2:0][7:0] held_reg, held_next;

    logic [MAX_RUN-1:0][7:0] ebuf;
    logic [RUN_CNT_W-1:0]    ecnt;
    logic                    accept;
    hex_t                    hx, h0, h1, h2;
    utf8_t                   enc;
    logic [15:0]             cp;
    logic [1:0]              nheld;

    function automatic logic [1:0] held_count(input phase_t p);
        case (p)
            PH_HEX1: return 2'd1;
            PH_HEX2: return 2'd2;
            PH_HEX3: return 2'd3;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic in_unicode(input phase_t p);
        return (p == PH_U) || (p == PH_HEX1) || (p == PH_HEX2) || (p == PH_HEX3);
    endfunction

    assign accept     = item_valid && !item_stall;
    assign item_stall = q_stat.full;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        ebuf       = '0;
        ecnt       = '0;
        hx         = hex_decode(item.in_byte);
        h0         = hex_decode(held_reg[0]);
        h1         = hex_decode(held_reg[1]);
        h2         = hex_decode(held_reg[2]);
        cp         = {h0.val, h1.val, h2.val, hx.val};
        enc        = utf8_encode(cp);
        nheld      = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (item.in_byte == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end else begin
                    ebuf[ecnt] = item.in_byte;
                    ecnt       = ecnt + 1'b1;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_IDLE;
                case (item.in_byte)
                    CH_LB:     begin ebuf[ecnt] = CODE_BS; ecnt = ecnt + 1'b1; end
                    CH_LF:     begin ebuf[ecnt] = CODE_FF; ecnt = ecnt + 1'b1; end
                    CH_LN:     begin ebuf[ecnt] = CODE_LF; ecnt = ecnt + 1'b1; end
                    CH_LR:     begin ebuf[ecnt] = CODE_CR; ecnt = ecnt + 1'b1; end
                    CH_LT:     begin ebuf[ecnt] = CODE_HT; ecnt = ecnt + 1'b1; end
                    CH_SLASH,
                    CH_QUOTE,
                    CH_BSLASH: begin ebuf[ecnt] = item.in_byte; ecnt = ecnt + 1'b1; end
                    CH_LU:     phase_next = PH_U;
                    default:
                    begin
                        // unknown escape: backslash, then the byte as is
                        ebuf[ecnt] = CH_BSLASH;
                        ecnt       = ecnt + 1'b1;
                        ebuf[ecnt] = item.in_byte;
                        ecnt       = ecnt + 1'b1;
                    end
                endcase
            end
            PH_U, PH_HEX1, PH_HEX2, PH_HEX3:
            begin
                if (hx.ok) begin
                    case (phase_reg)
                        PH_U:
                        begin
                            held_next[0] = item.in_byte;
                            phase_next   = PH_HEX1;
                        end
                        PH_HEX1:
                        begin
                            held_next[1] = item.in_byte;
                            phase_next   = PH_HEX2;
                        end
                        PH_HEX2:
                        begin
                            held_next[2] = item.in_byte;
                            phase_next   = PH_HEX3;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            for (int k = 0; k < 3; k++) begin
                                if (2'(k) < enc.len) begin
                                    ebuf[ecnt] = enc.b[k];
                                    ecnt       = ecnt + 1'b1;
                                end
                            end
                        end
                    endcase
                end else begin
                    // broken \u: replay it literally, then take the byte afresh
                    nheld      = held_count(phase_reg);
                    ebuf[ecnt] = CH_BSLASH;
                    ecnt       = ecnt + 1'b1;
                    ebuf[ecnt] = CH_LU;
                    ecnt       = ecnt + 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < nheld) begin
                            ebuf[ecnt] = held_reg[k];
                            ecnt       = ecnt + 1'b1;
                        end
                    end
                    if (item.in_byte == CH_BSLASH) begin
                        phase_next = PH_ESC;
                    end else begin
                        phase_next = PH_IDLE;
                        ebuf[ecnt] = item.in_byte;
                        ecnt       = ecnt + 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // string end: flush whatever escape is still open
        if (item.in_string_end) begin
            nheld = held_count(phase_next);
            if (phase_next != PH_IDLE) begin
                ebuf[ecnt] = CH_BSLASH;
                ecnt       = ecnt + 1'b1;
            end
            if (in_unicode(phase_next)) begin
                ebuf[ecnt] = CH_LU;
                ecnt       = ecnt + 1'b1;
            end
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < nheld) begin
                    ebuf[ecnt] = held_next[k];
                    ecnt       = ecnt + 1'b1;
                end
            end
            phase_next = PH_IDLE;
        end
    end

    assign q_push         = accept && ((ecnt != '0) || item.in_string_end);
    assign q_data.bytes   = ebuf;
    assign q_data.count   = ecnt;
    assign q_data.str_end = item.in_string_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/jsu_queue.sv -----
// Run queue between front and back end of the unescaper.
// Small register FIFO of run_t entries; uses jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  run_t    push_data,
    input  logic    pop,
    output run_t    head,
    output q_stat_t q_stat
);

    run_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == CNT_FULL);
    assign q_stat.empty = (cnt_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/jsu_back.sv -----
// Back end of the unescaper: walks the head run one byte per cycle, while the
// output is not stalled, into the output register, marks run and string ends. Uses jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_stat_t   q_stat,
    input  run_t      head,
    output logic      q_pop,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    logic [RUN_CNT_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;
    logic                 load;
    logic                 have;
    logic                 last;

    assign have = !q_stat.empty;
    assign load = !out_valid_reg || !result_stall;
    assign last = (head.count == '0) || (idx_reg == head.count - 1'b1);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        if (load) begin
            out_valid_next = have;
            if (have) begin
                out_next.out_byte       = (head.count == '0) ? 8'h00 : head.bytes[idx_reg];
                out_next.out_byte_valid = (head.count != '0);
                out_next.out_run_last   = last;
                out_next.out_string_end = last && head.str_end;
                // retire the run after its last byte
                if (last) begin
                    q_pop    = 1'b1;
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
